// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clk / rst_n taken from the enclosing scope
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/rrp_pkg.sv =====
package rrp_pkg;

    localparam int unsigned AddrW = 64;
    localparam int unsigned WordW = 32;
    localparam int unsigned OpW   = 4;
    localparam int unsigned StW   = 2;

    localparam logic [OpW-1:0] OP_ABS64        = 4'd0;
    localparam logic [OpW-1:0] OP_HI20         = 4'd1;
    localparam logic [OpW-1:0] OP_LO12_I       = 4'd2;
    localparam logic [OpW-1:0] OP_LO12_S       = 4'd3;
    localparam logic [OpW-1:0] OP_PCREL_HI20   = 4'd4;
    localparam logic [OpW-1:0] OP_PCREL_LO12_I = 4'd5;
    localparam logic [OpW-1:0] OP_PCREL_LO12_S = 4'd6;
    localparam logic [OpW-1:0] OP_BRANCH       = 4'd7;
    localparam logic [OpW-1:0] OP_JAL          = 4'd8;
    localparam logic [OpW-1:0] OP_CALL         = 4'd9;
    localparam logic [OpW-1:0] OP_TLS_FIRST    = 4'd10;
    localparam logic [OpW-1:0] OP_TLS_LAST     = 4'd12;

    localparam logic [StW-1:0] ST_OK      = 2'd0;
    localparam logic [StW-1:0] ST_RANGE   = 2'd1;
    localparam logic [StW-1:0] ST_TLS     = 2'd2;
    localparam logic [StW-1:0] ST_UNKNOWN = 2'd3;

    localparam int unsigned BranchBits = 13;
    localparam int unsigned JalBits    = 21;

    typedef struct packed {
        logic [OpW-1:0]   op;
        logic [AddrW-1:0] symbol_addr;
        logic [AddrW-1:0] addend;
        logic [AddrW-1:0] site_addr;
        logic [WordW-1:0] instr_word;
    } req_t;

    typedef struct packed {
        logic [AddrW-1:0] patched;
        logic [StW-1:0]   status;
    } rsp_t;

    typedef struct packed {
        logic [OpW-1:0]   op;
        logic [AddrW-1:0] sum;
        logic [AddrW-1:0] site_addr;
        logic [WordW-1:0] instr_word;
    } sum_t;

    typedef struct packed {
        logic [OpW-1:0]   op;
        logic [AddrW-1:0] sum;
        logic [AddrW-1:0] delta;
        logic [WordW-1:0] instr_word;
    } delta_t;

    function automatic logic [WordW-1:0] put_hi20(logic [WordW-1:0] w, logic [AddrW-1:0] x);
        logic [WordW-1:0] t;
        t = x[WordW-1:0] + 32'h0000_0800;
        return {t[31:12], w[11:0]};
    endfunction

    // low 12 bits OR'ed over word bits 31:20; word bits 11:0 cleared
    function automatic logic [WordW-1:0] put_lo12_i(logic [WordW-1:0] w, logic [AddrW-1:0] x);
        return {w[31:20] | x[11:0], w[19:12], 12'h000};
    endfunction

    function automatic logic [WordW-1:0] put_lo12_s(logic [WordW-1:0] w, logic [AddrW-1:0] x);
        return {x[11:5], w[24:12], x[4:0], w[6:0]};
    endfunction

    function automatic logic [WordW-1:0] put_branch(logic [WordW-1:0] w, logic [AddrW-1:0] v);
        return {v[12], v[10:5], w[24:12], v[4:1], v[11], w[6:0]};
    endfunction

    function automatic logic [WordW-1:0] put_jal(logic [WordW-1:0] w, logic [AddrW-1:0] v);
        return {v[20], v[10:1], v[11], v[19:12], w[11:0]};
    endfunction

endpackage

// ===== hw/rtl/riscv_relocation_patcher.sv =====
// Each accepted request is registered through the sum, delta and patch stages, in that order, before done.
// Throughput: one item per cycle; busy stays low since every stage advances each cycle.
// The result shows for one cycle with done; the receiver cannot stall, so nothing backs up.
// Reset (rst_n, async, active low) clears the stage valid bits; data registers are not reset.
`include "assert_macros.svh"

module riscv_relocation_patcher (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rrp_pkg::req_t req,
    output logic          done,
    output rrp_pkg::rsp_t rsp
);

    logic            sum_valid;
    rrp_pkg::sum_t   sum_data;
    logic            delta_valid;
    rrp_pkg::delta_t delta_data;
    logic            accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    rrp_sum_stage u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (accept),
        .req       (req),
        .sum_valid (sum_valid),
        .sum_data  (sum_data)
    );

    rrp_delta_stage u_delta (
        .clk         (clk),
        .rst_n       (rst_n),
        .sum_valid   (sum_valid),
        .sum_data    (sum_data),
        .delta_valid (delta_valid),
        .delta_data  (delta_data)
    );

    rrp_patch_stage u_patch (
        .clk         (clk),
        .rst_n       (rst_n),
        .delta_valid (delta_valid),
        .delta_data  (delta_data),
        .done        (done),
        .rsp         (rsp)
    );

    `ASSERT_NEXT(a_accept_to_delta, accept, sum_valid ##1 delta_valid ##1 done)
    `ASSERT_IMPL(a_done_has_source, done, $past(delta_valid))
    `ASSERT_IMPL(a_tls_word_only, done && (rsp.status == rrp_pkg::ST_TLS), rsp.patched[63:32] == '0)

endmodule

// ===== hw/rtl/rrp_sum_stage.sv =====
module rrp_sum_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          valid,
    input  rrp_pkg::req_t req,
    output logic          sum_valid,
    output rrp_pkg::sum_t sum_data
);

    logic          valid_reg;
    rrp_pkg::sum_t data_reg;
    rrp_pkg::sum_t data_next;

    always_comb
    begin
        data_next.op         = req.op;
        data_next.sum        = req.symbol_addr + req.addend;
        data_next.site_addr  = req.site_addr;
        data_next.instr_word = req.instr_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid)
        begin
            data_reg <= data_next;
        end
    end

    assign sum_valid = valid_reg;
    assign sum_data  = data_reg;

endmodule

// ===== hw/rtl/rrp_delta_stage.sv =====
module rrp_delta_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sum_valid,
    input  rrp_pkg::sum_t   sum_data,
    output logic            delta_valid,
    output rrp_pkg::delta_t delta_data
);

    logic            valid_reg;
    rrp_pkg::delta_t data_reg;
    rrp_pkg::delta_t data_next;

    always_comb
    begin
        data_next.op         = sum_data.op;
        data_next.sum        = sum_data.sum;
        data_next.delta      = sum_data.sum - sum_data.site_addr;
        data_next.instr_word = sum_data.instr_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign delta_valid = valid_reg;
    assign delta_data  = data_reg;

endmodule

// ===== hw/rtl/rrp_patch_stage.sv =====
module rrp_patch_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            delta_valid,
    input  rrp_pkg::delta_t delta_data,
    output logic            done,
    output rrp_pkg::rsp_t   rsp
);

    localparam int unsigned BrHi  = rrp_pkg::BranchBits - 1;
    localparam int unsigned JalHi = rrp_pkg::JalBits - 1;

    logic          done_reg;
    rrp_pkg::rsp_t rsp_reg;
    rrp_pkg::rsp_t rsp_next;
    logic          br_fits;
    logic          jal_fits;
    logic [rrp_pkg::WordW-1:0] w;

    // signed fit: all bits above the field equal its sign bit
    assign br_fits  = (delta_data.delta[rrp_pkg::AddrW-1:BrHi] == '0)
                   || (delta_data.delta[rrp_pkg::AddrW-1:BrHi] == '1);
    assign jal_fits = (delta_data.delta[rrp_pkg::AddrW-1:JalHi] == '0)
                   || (delta_data.delta[rrp_pkg::AddrW-1:JalHi] == '1);
    assign w = delta_data.instr_word;

    always_comb
    begin
        rsp_next.patched = {{(rrp_pkg::AddrW-rrp_pkg::WordW){1'b0}}, w};
        rsp_next.status  = rrp_pkg::ST_OK;
        case (delta_data.op) inside
            rrp_pkg::OP_ABS64:
            begin
                rsp_next.patched = delta_data.sum;
            end
            rrp_pkg::OP_HI20:
            begin
                rsp_next.patched[rrp_pkg::WordW-1:0] = rrp_pkg::put_hi20(w, delta_data.sum);
            end
            rrp_pkg::OP_LO12_I:
            begin
                rsp_next.patched[rrp_pkg::WordW-1:0] = rrp_pkg::put_lo12_i(w, delta_data.sum);
            end
            rrp_pkg::OP_LO12_S:
            begin
                rsp_next.patched[rrp_pkg::WordW-1:0] = rrp_pkg::put_lo12_s(w, delta_data.sum);
            end
            rrp_pkg::OP_PCREL_HI20:
            begin
                rsp_next.patched[rrp_pkg::WordW-1:0] = rrp_pkg::put_hi20(w, delta_data.delta);
            end
            rrp_pkg::OP_PCREL_LO12_I:
            begin
                rsp_next.patched[rrp_pkg::WordW-1:0] = rrp_pkg::put_lo12_i(w, delta_data.delta);
            end
            rrp_pkg::OP_PCREL_LO12_S:
            begin
                rsp_next.patched[rrp_pkg::WordW-1:0] = rrp_pkg::put_lo12_s(w, delta_data.delta);
            end
            rrp_pkg::OP_BRANCH:
            begin
                if (br_fits)
                begin
                    rsp_next.patched[rrp_pkg::WordW-1:0] =
                        rrp_pkg::put_branch(w, delta_data.delta);
                end
                else
                begin
                    rsp_next.status = rrp_pkg::ST_RANGE;
                end
            end
            rrp_pkg::OP_JAL, rrp_pkg::OP_CALL:
            begin
                if (jal_fits)
                begin
                    rsp_next.patched[rrp_pkg::WordW-1:0] =
                        rrp_pkg::put_jal(w, delta_data.delta);
                end
                else
                begin
                    rsp_next.status = rrp_pkg::ST_RANGE;
                end
            end
            [rrp_pkg::OP_TLS_FIRST:rrp_pkg::OP_TLS_LAST]:
            begin
                rsp_next.status = rrp_pkg::ST_TLS;
            end
            default:
            begin
                rsp_next.status = rrp_pkg::ST_UNKNOWN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= delta_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (delta_valid)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    rrp_pkg::req_t req;
    rrp_pkg::rsp_t rsp;

    rrp_pkg::rsp_t pending_patches[$];
    rrp_pkg::rsp_t oldest;
    int   error_count;
    int   burst_left;

    riscv_relocation_patcher u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // rounded upper 20 bits into a U-type word
    function automatic logic [31:0] fill_upper(logic [31:0] w, logic [63:0] x);
        logic [63:0] rounded;
        rounded = x + 64'h800;
        return (w & 32'h0000_0fff) | {rounded[31:12], 12'h000};
    endfunction

    // low 12 bits are OR'ed over the I-type immediate; bits 11:0 of the word are cleared
    function automatic logic [31:0] fill_lo_i(logic [31:0] w, logic [63:0] x);
        return (w & 32'hffff_f000) | {x[11:0], 20'h00000};
    endfunction

    function automatic logic [31:0] fill_lo_s(logic [31:0] w, logic [63:0] x);
        return (w & 32'h01ff_f07f) | {x[11:5], 13'h0000, x[4:0], 7'h00};
    endfunction

    function automatic rrp_pkg::rsp_t apply_reloc(rrp_pkg::req_t r);
        logic [63:0]        sum;
        logic [63:0]        delta;
        logic signed [63:0] offset;
        logic [31:0]        w;
        rrp_pkg::rsp_t      e;
        sum      = r.symbol_addr + r.addend;
        delta    = sum - r.site_addr;
        offset   = delta;
        w        = r.instr_word;
        e.patched = {32'h0, w};
        e.status  = rrp_pkg::ST_OK;
        case (r.op)
            rrp_pkg::OP_ABS64:        e.patched = sum;
            rrp_pkg::OP_HI20:         e.patched = {32'h0, fill_upper(w, sum)};
            rrp_pkg::OP_LO12_I:       e.patched = {32'h0, fill_lo_i(w, sum)};
            rrp_pkg::OP_LO12_S:       e.patched = {32'h0, fill_lo_s(w, sum)};
            rrp_pkg::OP_PCREL_HI20:   e.patched = {32'h0, fill_upper(w, delta)};
            rrp_pkg::OP_PCREL_LO12_I: e.patched = {32'h0, fill_lo_i(w, delta)};
            rrp_pkg::OP_PCREL_LO12_S: e.patched = {32'h0, fill_lo_s(w, delta)};
            rrp_pkg::OP_BRANCH:
            begin
                if (offset >= -64'sd4096 && offset <= 64'sd4095)
                begin
                    w = w & ~32'hfe00_0f80;
                    w = w | {delta[12], delta[10:5], 13'h0000, delta[4:1], delta[11], 7'h00};
                    e.patched = {32'h0, w};
                end
                else
                begin
                    e.status = rrp_pkg::ST_RANGE;
                end
            end
            rrp_pkg::OP_JAL, rrp_pkg::OP_CALL:
            begin
                if (offset >= -64'sd1048576 && offset <= 64'sd1048575)
                    e.patched = {32'h0, delta[20], delta[10:1], delta[11], delta[19:12], w[11:0]};
                else
                    e.status = rrp_pkg::ST_RANGE;
            end
            default:
            begin
                if (r.op >= rrp_pkg::OP_TLS_FIRST && r.op <= rrp_pkg::OP_TLS_LAST)
                    e.status = rrp_pkg::ST_TLS;
                else
                    e.status = rrp_pkg::ST_UNKNOWN;
            end
        endcase
        return e;
    endfunction

    function automatic rrp_pkg::req_t reloc(logic [3:0] op, logic [63:0] sym, logic [63:0] add,
                                            logic [63:0] site, logic [31:0] word);
        rrp_pkg::req_t r;
        r.op          = op;
        r.symbol_addr = sym;
        r.addend      = add;
        r.site_addr   = site;
        r.instr_word  = word;
        return r;
    endfunction

    // random symbol, addend chosen so that sum - site equals the given offset
    function automatic rrp_pkg::req_t reloc_at(logic [3:0] op, logic [63:0] site,
                                               logic [63:0] offset, logic [31:0] word);
        logic [63:0] sym;
        sym = rand64();
        return reloc(op, sym, site + offset - sym, site, word);
    endfunction

    function automatic logic [63:0] pick_offset(logic [3:0] op);
        logic [63:0] limit;
        logic [63:0] edge_val;
        logic [63:0] v;
        if (op == rrp_pkg::OP_BRANCH)
            limit = 64'd4096;
        else if (op == rrp_pkg::OP_JAL || op == rrp_pkg::OP_CALL)
            limit = 64'd1048576;
        else
            limit = 64'h8000_0000;
        case ($urandom_range(0, 3))
            0: v = rand64();
            1:
            begin
                edge_val = limit - 64'd4 + 64'($urandom_range(0, 7));
                v = $urandom_range(0, 1) ? edge_val : -edge_val;
            end
            2: v = (rand64() & ((limit << 1) - 64'd1)) - limit;
            default: v = 64'($urandom_range(0, 127)) - 64'd64;
        endcase
        return v;
    endfunction

    task automatic idle_sender(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start           = 1'b0;
            req.op          = 4'($urandom);
            req.symbol_addr = rand64();
            req.addend      = rand64();
            req.site_addr   = rand64();
            req.instr_word  = $urandom;
        end
    endtask

    task automatic send_reloc(rrp_pkg::req_t r);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 6));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        start = 1'b1;
        req   = r;
        do
            @(posedge clk);
        while (busy);
        pending_patches.push_back(apply_reloc(r));
    endtask

    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (pending_patches.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic test_absolute_forms();
        send_reloc(reloc(rrp_pkg::OP_ABS64, '1, 64'h1, rand64(), 32'hffff_ffff));
        send_reloc(reloc(rrp_pkg::OP_ABS64, 64'h0, 64'h8000_0000_0000_0000, 64'h0, 32'h0));
        send_reloc(reloc(rrp_pkg::OP_HI20, 64'h1234_5800, 64'h0, 64'h0, 32'hffff_ffff));
        // rounding carries out of the 20-bit field
        send_reloc(reloc(rrp_pkg::OP_HI20, 64'hffff_ffff_ffff_f7ff, 64'h1, 64'h0, 32'h0000_0037));
        send_reloc(reloc(rrp_pkg::OP_LO12_I, 64'h0000_0fff, 64'h0, 64'h0, 32'hffff_ffff));
        send_reloc(reloc(rrp_pkg::OP_LO12_S, 64'h0000_0fff, 64'h0, 64'h0, 32'h0));
        send_reloc(reloc(rrp_pkg::OP_LO12_S, 64'h0, 64'h0, 64'h0, 32'hffff_ffff));
    endtask

    task automatic test_pcrel_forms();
        send_reloc(reloc_at(rrp_pkg::OP_PCREL_HI20, rand64(), 64'h7fff_f7ff, 32'h0000_0517));
        send_reloc(reloc_at(rrp_pkg::OP_PCREL_HI20, rand64(), -64'd2049, 32'hffff_ffff));
        send_reloc(reloc_at(rrp_pkg::OP_PCREL_LO12_I, rand64(), -64'd1, 32'h0005_0513));
        send_reloc(reloc_at(rrp_pkg::OP_PCREL_LO12_S, rand64(), 64'h7ff, 32'hffff_ffff));
    endtask

    task automatic test_branch_range();
        // odd offset: bit 0 dropped silently
        send_reloc(reloc_at(rrp_pkg::OP_BRANCH, rand64(), 64'd4095, 32'h0000_0063));
        send_reloc(reloc_at(rrp_pkg::OP_BRANCH, rand64(), -64'd4096, 32'hffff_ffff));
        send_reloc(reloc_at(rrp_pkg::OP_BRANCH, rand64(), 64'd4096, 32'h0000_0063));
        send_reloc(reloc_at(rrp_pkg::OP_BRANCH, rand64(), -64'd4097, 32'hffff_ffff));
    endtask

    task automatic test_jump_range();
        send_reloc(reloc_at(rrp_pkg::OP_JAL, rand64(), 64'd1048575, 32'h0000_006f));
        send_reloc(reloc_at(rrp_pkg::OP_JAL, rand64(), -64'd1048576, 32'hffff_ffff));
        send_reloc(reloc_at(rrp_pkg::OP_JAL, rand64(), 64'd1048576, 32'h0000_00ef));
        send_reloc(reloc_at(rrp_pkg::OP_CALL, rand64(), -64'd1048577, 32'hffff_ffff));
        send_reloc(reloc_at(rrp_pkg::OP_CALL, rand64(), 64'h12345, 32'h0000_00ef));
    endtask

    task automatic test_flagged_types();
        for (int k = int'(rrp_pkg::OP_TLS_FIRST); k < (1 << rrp_pkg::OpW); k++)
            send_reloc(reloc(4'(k), rand64(), rand64(), rand64(), $urandom));
    endtask

    task automatic test_random_mix(int count);
        logic [3:0]  op;
        logic [31:0] word;
        repeat (count)
        begin
            op = ($urandom_range(0, 99) < 75) ? 4'($urandom_range(0, rrp_pkg::OP_CALL))
                                              : 4'($urandom);
            case ($urandom_range(0, 7))
                0:       word = '0;
                1:       word = '1;
                default: word = $urandom;
            endcase
            if ($urandom_range(0, 2) == 0)
                send_reloc(reloc(op, rand64(), rand64(), rand64(), word));
            else
                send_reloc(reloc_at(op, rand64(), pick_offset(op), word));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_patches.size() == 0)
            begin
                $display("%0t: unexpected result patched=%h status=%0d",
                         $time, rsp.patched, rsp.status);
                error_count++;
            end
            else
            begin
                oldest = pending_patches.pop_front();
                if (rsp.patched !== oldest.patched)
                begin
                    $display("%0t: patched mismatch expected=%h actual=%h",
                             $time, oldest.patched, rsp.patched);
                    error_count++;
                end
                if (rsp.status !== oldest.status)
                begin
                    $display("%0t: status mismatch expected=%0d actual=%0d",
                             $time, oldest.status, rsp.status);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        error_count = 0;
        burst_left  = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_absolute_forms();
        test_pcrel_forms();
        test_branch_range();
        test_jump_range();
        test_flagged_types();
        drain_results();
        test_random_mix(950);
        drain_results();
        test_random_mix(950);
        drain_results();

        if (pending_patches.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rrp_pkg.sv
hw/rtl/rrp_sum_stage.sv
hw/rtl/rrp_delta_stage.sv
hw/rtl/rrp_patch_stage.sv
hw/rtl/riscv_relocation_patcher.sv
verif/tb.sv
